>>> rtl/core/ifpm_pkg.sv
`timescale 1ns / 1ps
package ifpm_pkg;

	// default sizes
	localparam int IFPM_DIM_BITS  = 14;
	localparam int IFPM_FRAC_BITS = 4;

	// pointer fields are fixed at 20 bits signed
	localparam int PTR_BITS  = 20;
	localparam int IN_FIELDS = 2 * PTR_BITS;
	localparam int IN_BITS   = ((IN_FIELDS + 7) / 8) * 8;

	// APB register map: register i at byte address 4*i
	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_SCALE_MODE         = 3'd0,
		REG_LOGICAL_WIDTH      = 3'd1,
		REG_LOGICAL_HEIGHT     = 3'd2,
		REG_FRAMEBUFFER_WIDTH  = 3'd3,
		REG_FRAMEBUFFER_HEIGHT = 3'd4
	} reg_idx_t;

	// scale mode codes
	localparam logic MODE_NATIVE = 1'b0;
	localparam logic MODE_FIT    = 1'b1;

	// layout sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_W,
		ST_DIV_W,
		ST_LOAD_H,
		ST_DIV_H,
		ST_SCALE,
		ST_SIZE,
		ST_OFFSET
	} lay_state_t;

	// layout unit status toward the point pipeline
	typedef struct packed {
		logic busy;
		logic valid;
		logic crop;
	} lay_status_t;

endpackage

>>> rtl/core/ifpm_layout.sv
`timescale 1ns / 1ps
module ifpm_layout
	import ifpm_pkg::*;
#(
	parameter int DIM_BITS = IFPM_DIM_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       scale_mode,
	input  logic [DIM_BITS-1:0]        logical_width,
	input  logic [DIM_BITS-1:0]        logical_height,
	input  logic [DIM_BITS-1:0]        fb_width,
	input  logic [DIM_BITS-1:0]        fb_height,
	output lay_status_t                status,
	output logic [DIM_BITS-1:0]        scale,
	output logic signed [DIM_BITS-1:0] cx,
	output logic signed [DIM_BITS-1:0] cy,
	output logic [DIM_BITS-1:0]        cw,
	output logic [DIM_BITS-1:0]        ch,
	output logic [DIM_BITS-1:0]        lw,
	output logic [DIM_BITS-1:0]        lh
);

	localparam int CNT_BITS = $clog2(DIM_BITS);

	lay_state_t state_q, state_nxt;

	logic                       div_load, div_step, div_w, busy;
	logic [DIM_BITS-1:0]        rem_q, quo_q, rx_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic [DIM_BITS-1:0]        scale_q, cw_q, ch_q, lw_q, lh_q;
	logic signed [DIM_BITS-1:0] cx_q, cy_q;
	logic                       valid_q, crop_q;

	logic                       native, lay_ok;
	logic [DIM_BITS-1:0]        dividend, divisor, ratio_min, scale_fit;
	logic [DIM_BITS:0]          sh, sh_sub;
	logic                       ge;
	logic [2*DIM_BITS-1:0]      prod_w, prod_h;
	logic [DIM_BITS:0]          diff_w, diff_h;

	assign native = (scale_mode == MODE_NATIVE);
	assign lay_ok = (fb_width != '0) && (fb_height != '0) &&
		(native || ((logical_width != '0) && (logical_height != '0)));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   state_nxt = ST_IDLE;
			ST_LOAD_W: state_nxt = ST_DIV_W;
			ST_DIV_W:  if (cnt_q == '0) state_nxt = ST_LOAD_H;
			ST_LOAD_H: state_nxt = ST_DIV_H;
			ST_DIV_H:  if (cnt_q == '0) state_nxt = ST_SCALE;
			ST_SCALE:  state_nxt = ST_SIZE;
			ST_SIZE:   state_nxt = ST_OFFSET;
			ST_OFFSET: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
		if (start) state_nxt = ST_LOAD_W;
	end

	// sequencer outputs
	always_comb begin
		div_load = 1'b0;
		div_step = 1'b0;
		div_w    = 1'b0;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_LOAD_W: begin
				div_load = 1'b1;
				div_w    = 1'b1;
			end
			ST_DIV_W:  begin
				div_step = 1'b1;
				div_w    = 1'b1;
			end
			ST_LOAD_H: div_load = 1'b1;
			ST_DIV_H:  div_step = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD_W;
		end else begin
			state_q <= state_nxt;
		end
	end

	// shared restoring divider, one quotient bit a cycle
	assign dividend = div_w ? fb_width : fb_height;
	assign divisor  = div_w ? logical_width : logical_height;
	assign sh       = {rem_q, quo_q[DIM_BITS-1]};
	assign sh_sub   = sh - {1'b0, divisor};
	assign ge       = (sh >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (div_load) begin
			rem_q <= '0;
			quo_q <= dividend;
			cnt_q <= CNT_BITS'(DIM_BITS - 1);
		end else if (div_step) begin
			rem_q <= ge ? sh_sub[DIM_BITS-1:0] : sh[DIM_BITS-1:0];
			quo_q <= {quo_q[DIM_BITS-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
		// width ratio is done when the height division is loaded
		if (state_q == ST_LOAD_H) rx_q <= quo_q;
	end

	// scale: smaller ratio, at least one
	assign ratio_min = (rx_q < quo_q) ? rx_q : quo_q;
	assign scale_fit = (ratio_min == '0) ? DIM_BITS'(1) : ratio_min;

	// content size never exceeds the framebuffer unless scale was forced to one
	assign prod_w = {{DIM_BITS{1'b0}}, logical_width} * {{DIM_BITS{1'b0}}, scale_q};
	assign prod_h = {{DIM_BITS{1'b0}}, logical_height} * {{DIM_BITS{1'b0}}, scale_q};

	// floor-half margins
	assign diff_w = {1'b0, fb_width} - {1'b0, cw_q};
	assign diff_h = {1'b0, fb_height} - {1'b0, ch_q};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SCALE: begin
				if (!lay_ok) scale_q <= '0;
				else if (native) scale_q <= DIM_BITS'(1);
				else scale_q <= scale_fit;
			end
			ST_SIZE: begin
				cw_q <= native ? fb_width : prod_w[DIM_BITS-1:0];
				ch_q <= native ? fb_height : prod_h[DIM_BITS-1:0];
				lw_q <= native ? fb_width : logical_width;
				lh_q <= native ? fb_height : logical_height;
			end
			ST_OFFSET: begin
				cx_q <= (native || !lay_ok) ? '0 : $signed(diff_w[DIM_BITS:1]);
				cy_q <= (native || !lay_ok) ? '0 : $signed(diff_h[DIM_BITS:1]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			crop_q  <= 1'b0;
		end else if (state_q == ST_OFFSET) begin
			valid_q <= lay_ok;
			crop_q  <= lay_ok && !native && ((cw_q > fb_width) || (ch_q > fb_height));
		end
	end

	assign status = '{busy: busy, valid: valid_q, crop: crop_q};
	assign scale  = scale_q;
	assign cx     = cx_q;
	assign cy     = cy_q;
	assign cw     = cw_q;
	assign ch     = ch_q;
	assign lw     = lw_q;
	assign lh     = lh_q;

endmodule

>>> rtl/core/ifpm_div_pipe.sv
`timescale 1ns / 1ps
module ifpm_div_pipe
	import ifpm_pkg::*;
#(
	parameter int DIM_BITS = IFPM_DIM_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DIM_BITS-1:0] divisor,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DIM_BITS-1:0] in_num_x,
	input  logic [DIM_BITS-1:0] in_num_y,
	input  logic                in_inside,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIM_BITS-1:0] out_quo_x,
	output logic [DIM_BITS-1:0] out_quo_y,
	output logic                out_inside
);

	// one quotient bit per stage, two lanes; quo holds the numerator shifting out
	logic                dvld_s   [DIM_BITS];
	logic [DIM_BITS-1:0] remx_s   [DIM_BITS];
	logic [DIM_BITS-1:0] quox_s   [DIM_BITS];
	logic [DIM_BITS-1:0] remy_s   [DIM_BITS];
	logic [DIM_BITS-1:0] quoy_s   [DIM_BITS];
	logic                inside_s [DIM_BITS];
	logic [DIM_BITS-1:0] dfree;

	for (genvar k = 0; k < DIM_BITS; k++) begin : g_stage
		logic                v_in, side_in, gex, gey;
		logic [DIM_BITS-1:0] rx_in, qx_in, ry_in, qy_in;
		logic [DIM_BITS:0]   shx, shy, subx, suby;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign side_in = in_inside;
			assign rx_in   = '0;
			assign qx_in   = in_num_x;
			assign ry_in   = '0;
			assign qy_in   = in_num_y;
		end else begin : g_next
			assign v_in    = dvld_s[k-1];
			assign side_in = inside_s[k-1];
			assign rx_in   = remx_s[k-1];
			assign qx_in   = quox_s[k-1];
			assign ry_in   = remy_s[k-1];
			assign qy_in   = quoy_s[k-1];
		end

		// stage is free when empty or its content moves on
		if (k == DIM_BITS - 1) begin : g_last
			assign dfree[k] = !dvld_s[k] || out_ready;
		end else begin : g_mid
			assign dfree[k] = !dvld_s[k] || dfree[k+1];
		end

		// trial subtract per lane
		assign shx  = {rx_in, qx_in[DIM_BITS-1]};
		assign shy  = {ry_in, qy_in[DIM_BITS-1]};
		assign subx = shx - {1'b0, divisor};
		assign suby = shy - {1'b0, divisor};
		assign gex  = (shx >= {1'b0, divisor});
		assign gey  = (shy >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k] <= 1'b0;
			end else if (dfree[k]) begin
				dvld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (dfree[k] && v_in) begin
				remx_s[k]   <= gex ? subx[DIM_BITS-1:0] : shx[DIM_BITS-1:0];
				remy_s[k]   <= gey ? suby[DIM_BITS-1:0] : shy[DIM_BITS-1:0];
				quox_s[k]   <= {qx_in[DIM_BITS-2:0], gex};
				quoy_s[k]   <= {qy_in[DIM_BITS-2:0], gey};
				inside_s[k] <= side_in;
			end
		end
	end

	assign in_ready   = dfree[0];
	assign out_valid  = dvld_s[DIM_BITS-1];
	assign out_quo_x  = quox_s[DIM_BITS-1];
	assign out_quo_y  = quoy_s[DIM_BITS-1];
	assign out_inside = inside_s[DIM_BITS-1];

endmodule

>>> rtl/core/integer_fit_pointer_mapper.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// s_*       in   s_tvalid / s_tready           pointer_x, pointer_y
// m_*       out  m_tvalid / m_tready           hit, logical coords, layout
// APB       in   psel & penable & pwrite       layout registers, pready tied high
//
// One point per cycle unless stalled by m_tready or a busy layout; stages: two range-check
// stages, a DIM_BITS-stage restoring divider (one quotient bit per stage), output register.
// After reset and after every register write the layout sequencer runs through two shared
// serial divisions, scale, size and offsets; s_tready stays low meanwhile.
// Each stage holds its item while the next is full; bubbles are squeezed out.
module integer_fit_pointer_mapper
	import ifpm_pkg::*;
#(
	parameter int DIM_BITS  = IFPM_DIM_BITS,
	parameter int FRAC_BITS = IFPM_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// stream in
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [19:0] pointer_x, [39:20] pointer_y
	input  logic [IN_BITS-1:0]       s_tdata,
	// stream out
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [0] hit, then logical_x, logical_y, scale_factor, content_x, content_y
	// (DIM_BITS each), then cropped, zero padded to bytes
	output logic [((5*DIM_BITS+2+7)/8)*8-1:0] m_tdata,
	// APB
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int OUT_FIELDS = 5 * DIM_BITS + 2;
	localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;
	localparam int XW = ((PTR_BITS > DIM_BITS + FRAC_BITS + 1) ?
		PTR_BITS : DIM_BITS + FRAC_BITS + 1) + 1;

	// registers
	logic                mode_q;
	logic [DIM_BITS-1:0] lwid_q, lhgt_q, fbw_q, fbh_q;
	logic                cfg_wr;
	reg_idx_t            reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIT;
			lwid_q <= DIM_BITS'(320);
			lhgt_q <= DIM_BITS'(240);
			fbw_q  <= DIM_BITS'(640);
			fbh_q  <= DIM_BITS'(480);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SCALE_MODE:         mode_q <= pwdata[0];
				REG_LOGICAL_WIDTH:      lwid_q <= pwdata[DIM_BITS-1:0];
				REG_LOGICAL_HEIGHT:     lhgt_q <= pwdata[DIM_BITS-1:0];
				REG_FRAMEBUFFER_WIDTH:  fbw_q  <= pwdata[DIM_BITS-1:0];
				REG_FRAMEBUFFER_HEIGHT: fbh_q  <= pwdata[DIM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCALE_MODE:         prdata = APB_DATA_BITS'(mode_q);
			REG_LOGICAL_WIDTH:      prdata = APB_DATA_BITS'(lwid_q);
			REG_LOGICAL_HEIGHT:     prdata = APB_DATA_BITS'(lhgt_q);
			REG_FRAMEBUFFER_WIDTH:  prdata = APB_DATA_BITS'(fbw_q);
			REG_FRAMEBUFFER_HEIGHT: prdata = APB_DATA_BITS'(fbh_q);
			default:                prdata = '0;
		endcase
	end

	// layout sequencer
	lay_status_t                lay;
	logic [DIM_BITS-1:0]        lay_scale, lay_cw, lay_ch, lay_lw, lay_lh;
	logic signed [DIM_BITS-1:0] lay_cx, lay_cy;

	ifpm_layout #(
		.DIM_BITS(DIM_BITS)
	) u_layout (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (cfg_wr),
		.scale_mode     (mode_q),
		.logical_width  (lwid_q),
		.logical_height (lhgt_q),
		.fb_width       (fbw_q),
		.fb_height      (fbh_q),
		.status         (lay),
		.scale          (lay_scale),
		.cx             (lay_cx),
		.cy             (lay_cy),
		.cw             (lay_cw),
		.ch             (lay_ch),
		.lw             (lay_lw),
		.lh             (lay_lh)
	);

	// layout in pointer units
	logic signed [XW-1:0] fbw_fx, fbh_fx, cw_fx, ch_fx, cx_fx, cy_fx;

	assign fbw_fx = $signed(XW'(fbw_q) << FRAC_BITS);
	assign fbh_fx = $signed(XW'(fbh_q) << FRAC_BITS);
	assign cw_fx  = $signed(XW'(lay_cw) << FRAC_BITS);
	assign ch_fx  = $signed(XW'(lay_ch) << FRAC_BITS);
	assign cx_fx  = XW'(lay_cx) <<< FRAC_BITS;
	assign cy_fx  = XW'(lay_cy) <<< FRAC_BITS;

	// flow control
	logic free_s1, free_s2, div_in_ready, out_free;
	logic v_s1, v_s2;

	assign free_s2  = !v_s2 || div_in_ready;
	assign free_s1  = !v_s1 || free_s2;
	assign s_tready = free_s1 && !lay.busy;

	// stage 1: sign extend, framebuffer bounds
	logic signed [XW-1:0] px, py, px_s1, py_s1;
	logic                 infb_s1;

	assign px = XW'($signed(s_tdata[PTR_BITS-1:0]));
	assign py = XW'($signed(s_tdata[2*PTR_BITS-1:PTR_BITS]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free_s1) begin
			v_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && s_tvalid && s_tready) begin
			px_s1   <= px;
			py_s1   <= py;
			infb_s1 <= !px[XW-1] && !py[XW-1] && (px < fbw_fx) && (py < fbh_fx);
		end
	end

	// stage 2: content offset and bounds
	logic signed [XW-1:0] ux, uy;
	logic [DIM_BITS-1:0]  numx_s2, numy_s2;
	logic                 inside_s2;

	assign ux = px_s1 - cx_fx;
	assign uy = py_s1 - cy_fx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && v_s1) begin
			numx_s2   <= ux[FRAC_BITS +: DIM_BITS];
			numy_s2   <= uy[FRAC_BITS +: DIM_BITS];
			inside_s2 <= lay.valid && infb_s1 && !ux[XW-1] && !uy[XW-1] &&
				(ux < cw_fx) && (uy < ch_fx);
		end
	end

	// whole pixels divided by scale
	logic                div_out_valid, div_inside;
	logic [DIM_BITS-1:0] quo_x, quo_y;

	ifpm_div_pipe #(
		.DIM_BITS(DIM_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.divisor    (lay_scale),
		.in_valid   (v_s2),
		.in_ready   (div_in_ready),
		.in_num_x   (numx_s2),
		.in_num_y   (numy_s2),
		.in_inside  (inside_s2),
		.out_valid  (div_out_valid),
		.out_ready  (out_free),
		.out_quo_x  (quo_x),
		.out_quo_y  (quo_y),
		.out_inside (div_inside)
	);

	// output register
	logic                out_v_q, hit, hit_q, crop_q;
	logic [DIM_BITS-1:0] lx_q, ly_q, scale_q;
	logic [DIM_BITS-1:0] cx_q, cy_q;

	assign out_free = !out_v_q || m_tready;
	assign hit      = div_inside && (quo_x < lay_lw) && (quo_y < lay_lh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && div_out_valid) begin
			hit_q   <= hit;
			lx_q    <= hit ? quo_x : '0;
			ly_q    <= hit ? quo_y : '0;
			scale_q <= lay_scale;
			cx_q    <= lay_cx;
			cy_q    <= lay_cy;
			crop_q  <= lay.crop;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_BITS'({crop_q, cy_q, cx_q, scale_q, ly_q, lx_q, hit_q});

endmodule
